// ===== hdl/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sensor link frame deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned IMU_FRAME_BYTES   = 36;
  localparam int unsigned RADIO_FRAME_BYTES = 46;

  localparam int unsigned HDR_BYTES   = 5;
  localparam int unsigned WIN_BYTES   = HDR_BYTES - 1;
  localparam int unsigned FILL_W      = $clog2(HDR_BYTES);
  localparam int unsigned REM_W       = 17;
  localparam int unsigned RADIO_SKIP  = 8;
  localparam int unsigned IDX_W       = $clog2(RADIO_SKIP + 1);

  localparam logic [7:0] SYNC_A     = 8'h52;
  localparam logic [7:0] SYNC_B     = 8'h54;
  localparam logic [7:0] TYPE_IMU   = 8'h24;
  localparam logic [7:0] TYPE_GNSS  = 8'h21;
  localparam logic [7:0] TYPE_RADIO = 8'h22;
  localparam logic [7:0] TRAIL_LF   = 8'h0A;
  localparam logic [7:0] TRAIL_CR   = 8'h0D;

  localparam logic [15:0] GNSS_MIN_LEN = 16'd4;

  localparam logic [1:0] STREAM_IMU   = 2'd0;
  localparam logic [1:0] STREAM_GNSS  = 2'd1;
  localparam logic [1:0] STREAM_RADIO = 2'd2;
  localparam logic [1:0] STREAM_NONE  = 2'd3;

  localparam logic [1:0] STAT_GOOD      = 2'd0;
  localparam logic [1:0] STAT_BAD_TRAIL = 2'd1;
  localparam logic [1:0] STAT_BAD_TYPE  = 2'd2;
  localparam logic [1:0] STAT_BAD_LEN   = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [1:0]  stream;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] link_counter;
    logic [15:0] sensor_counter;
    logic [15:0] frame_crc;
  } sld_result_t;

endpackage

// ===== hdl/sld_input_stage.sv =====
// ----------------------------------------------------------------------------
// sld_input_stage
// Input word register; holds a received byte until the core takes it.
// ----------------------------------------------------------------------------
module sld_input_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       in_valid_o,
  output logic [7:0] in_byte_o
);
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  assign rx_stall_o = in_valid_q & ~advance_i;
  assign in_valid_o = in_valid_q;
  assign in_byte_o  = in_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!rx_stall_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!rx_stall_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

endmodule

// ===== hdl/sld_core.sv =====
// ----------------------------------------------------------------------------
// sld_core
// Header hunt and frame tracking; turns one byte into zero or one result.
// ----------------------------------------------------------------------------
module sld_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 proc_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output sld_pkg::sld_result_t res_o
);
  import sld_pkg::*;

  localparam logic [REM_W-1:0] IMU_LAST   = REM_W'(IMU_FRAME_BYTES - 1);
  localparam logic [REM_W-1:0] RADIO_LAST = REM_W'(RADIO_FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_SAT    = IDX_W'(RADIO_SKIP);

  logic [7:0]       win_q [WIN_BYTES];
  logic [7:0]       win_d [WIN_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic             in_frame_q, in_frame_d;
  logic [1:0]       stream_q, stream_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      link_q, link_d;
  logic [15:0]      sens_q, sens_d;
  logic [15:0]      crc_q, crc_d;
  logic             tok_q, tok_d;

  logic [7:0]  hdr_type;
  logic [15:0] hdr_len;
  logic        is_radio;
  logic        trail_hit;
  logic [7:0]  trail_exp;
  logic        payload;

  assign hdr_type = win_q[2];
  assign hdr_len  = {win_q[3], byte_i};
  assign is_radio = (stream_q == STREAM_RADIO);

  // expected trailer byte, counted back from the frame's last byte
  always_comb begin
    trail_hit = 1'b0;
    trail_exp = TRAIL_CR;
    if (rem_q == REM_W'(0)) begin
      trail_hit = 1'b1;
      trail_exp = TRAIL_CR;
    end else if (rem_q == REM_W'(1)) begin
      trail_hit = 1'b1;
      trail_exp = TRAIL_LF;
    end else if (is_radio && rem_q == REM_W'(2)) begin
      trail_hit = 1'b1;
      trail_exp = TRAIL_CR;
    end else if (is_radio && rem_q == REM_W'(3)) begin
      trail_hit = 1'b1;
      trail_exp = TRAIL_LF;
    end
  end

  always_comb begin
    case (stream_q)
      STREAM_IMU:  payload = (idx_q >= IDX_W'(4)) && (rem_q >= REM_W'(4));
      STREAM_GNSS: payload = (idx_q >= IDX_W'(4)) && (rem_q >= REM_W'(2));
      default:     payload = (idx_q == IDX_SAT) && (rem_q >= REM_W'(6));
    endcase
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    in_frame_d  = in_frame_q;
    stream_d    = stream_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    link_d      = link_q;
    sens_d      = sens_q;
    crc_d       = crc_q;
    tok_d       = tok_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (proc_i && !in_frame_q) begin
      if (fill_q != FILL_W'(WIN_BYTES) || win_q[0] != SYNC_A || win_q[1] != SYNC_B) begin
        // still filling, or sync mismatch: slide by one byte
        for (int i = 0; i < WIN_BYTES - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WIN_BYTES-1] = byte_i;
        if (fill_q != FILL_W'(WIN_BYTES)) begin
          fill_d = fill_q + FILL_W'(1);
        end
      end else begin
        fill_d = '0;
        in_frame_d = 1'b1;
        idx_d  = '0;
        link_d = '0;
        sens_d = '0;
        crc_d  = '0;
        tok_d  = 1'b1;
        case (hdr_type)
          TYPE_IMU: begin
            stream_d = STREAM_IMU;
            rem_d    = IMU_LAST;
          end
          TYPE_GNSS: begin
            stream_d = STREAM_GNSS;
            rem_d    = {1'b0, hdr_len} + REM_W'(1);
            if (hdr_len < GNSS_MIN_LEN) begin
              in_frame_d = in_frame_q;
              stream_d   = stream_q;
              rem_d      = rem_q;
              idx_d      = idx_q;
              link_d     = link_q;
              sens_d     = sens_q;
              crc_d      = crc_q;
              tok_d      = tok_q;
              res_valid_o = 1'b1;
              res_o.stream    = STREAM_NONE;
              res_o.frame_end = 1'b1;
              res_o.status    = STAT_BAD_LEN;
            end
          end
          TYPE_RADIO: begin
            stream_d = STREAM_RADIO;
            rem_d    = RADIO_LAST;
          end
          default: begin
            in_frame_d = in_frame_q;
            idx_d      = idx_q;
            link_d     = link_q;
            sens_d     = sens_q;
            crc_d      = crc_q;
            tok_d      = tok_q;
            res_valid_o = 1'b1;
            res_o.data_byte = hdr_type;
            res_o.stream    = STREAM_NONE;
            res_o.frame_end = 1'b1;
            res_o.status    = STAT_BAD_TYPE;
          end
        endcase
      end
    end else if (proc_i) begin
      if (!is_radio) begin
        if (idx_q == IDX_W'(0)) link_d[15:8] = byte_i;
        if (idx_q == IDX_W'(1)) link_d[7:0]  = byte_i;
        if (idx_q == IDX_W'(2)) sens_d[15:8] = byte_i;
        if (idx_q == IDX_W'(3)) sens_d[7:0]  = byte_i;
      end
      if (stream_q == STREAM_IMU) begin
        if (rem_q == REM_W'(3)) crc_d[15:8] = byte_i;
        if (rem_q == REM_W'(2)) crc_d[7:0]  = byte_i;
      end else if (is_radio) begin
        if (rem_q == REM_W'(5)) crc_d[15:8] = byte_i;
        if (rem_q == REM_W'(4)) crc_d[7:0]  = byte_i;
      end
      if (trail_hit && byte_i != trail_exp) begin
        tok_d = 1'b0;
      end

      if (rem_q == '0) begin
        in_frame_d  = 1'b0;
        fill_d      = '0;
        res_valid_o = 1'b1;
        res_o.stream         = stream_q;
        res_o.frame_end      = 1'b1;
        res_o.status         = tok_d ? STAT_GOOD : STAT_BAD_TRAIL;
        res_o.link_counter   = is_radio ? 16'd0 : link_d;
        res_o.sensor_counter = is_radio ? 16'd0 : sens_d;
        res_o.frame_crc      = (stream_q == STREAM_GNSS) ? 16'd0 : crc_d;
      end else begin
        rem_d = rem_q - REM_W'(1);
        if (idx_q != IDX_SAT) begin
          idx_d = idx_q + IDX_W'(1);
        end
        if (payload) begin
          res_valid_o      = 1'b1;
          res_o.data_byte  = byte_i;
          res_o.byte_valid = 1'b1;
          res_o.stream     = stream_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_BYTES; i++) begin
        win_q[i] <= '0;
      end
      fill_q     <= '0;
      in_frame_q <= 1'b0;
      stream_q   <= STREAM_IMU;
      rem_q      <= '0;
      idx_q      <= '0;
      link_q     <= '0;
      sens_q     <= '0;
      crc_q      <= '0;
      tok_q      <= 1'b1;
    end else begin
      win_q      <= win_d;
      fill_q     <= fill_d;
      in_frame_q <= in_frame_d;
      stream_q   <= stream_d;
      rem_q      <= rem_d;
      idx_q      <= idx_d;
      link_q     <= link_d;
      sens_q     <= sens_d;
      crc_q      <= crc_d;
      tok_q      <= tok_d;
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_BYTES))
    else $error("header window fill out of range");

  a_frame_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> fill_q == '0)
    else $error("window fill while inside a frame");

  a_end_not_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.frame_end && res_o.byte_valid))
    else $error("end item also flagged as payload");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_end) |=> !in_frame_q)
    else $error("frame still open after end item");

  a_err_when_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.stream == STREAM_NONE) |-> !in_frame_q)
    else $error("header error reported inside a frame");
`endif

endmodule

// ===== hdl/sld_output_stage.sv =====
// ----------------------------------------------------------------------------
// sld_output_stage
// Result register; decides when the core may take the next byte.
// ----------------------------------------------------------------------------
module sld_output_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  sld_pkg::sld_result_t res_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sld_pkg::sld_result_t res_o
);
  import sld_pkg::*;

  logic        out_valid_q;
  sld_result_t res_q;

  // register is free when empty or its word leaves this cycle
  assign advance_o   = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/sensor_link_frame_deframer.sv =====
// Path: a byte taken into the input register passes through the combinational
// core into the result register, taken only while that register is free.
// Throughput: one byte per cycle when not stalled, set by the single-pass core.
// A stalled output holds its word while the core is held; input stalls only then.
// Reset (rst_ni low, async) empties both registers and restarts the header hunt.
// ----------------------------------------------------------------------------
// sensor_link_frame_deframer
// Hunts for sensor link headers and splits frames into payload and end words.
// ----------------------------------------------------------------------------
module sensor_link_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic [1:0]  stream_o,
  output logic        frame_end_o,
  output logic [1:0]  status_o,
  output logic [15:0] link_counter_o,
  output logic [15:0] sensor_counter_o,
  output logic [15:0] frame_crc_o
);
  import sld_pkg::*;

  logic        advance;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        res_valid;
  sld_result_t res;
  sld_result_t out_res;

  sld_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .in_valid_o (in_valid),
    .in_byte_o  (in_byte)
  );

  sld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (in_valid & advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sld_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign data_byte_o      = out_res.data_byte;
  assign byte_valid_o     = out_res.byte_valid;
  assign stream_o         = out_res.stream;
  assign frame_end_o      = out_res.frame_end;
  assign status_o         = out_res.status;
  assign link_counter_o   = out_res.link_counter;
  assign sensor_counter_o = out_res.sensor_counter;
  assign frame_crc_o      = out_res.frame_crc;

endmodule
